/* rtl/lbr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the LSB-first bit reader.
// No dependencies; every other file imports this package.
package lbr_pkg;

  // Operation codes carried in the operation field of an input word.
  localparam logic [2:0] OP_WRITE      = 3'd0;
  localparam logic [2:0] OP_PEEK       = 3'd1;
  localparam logic [2:0] OP_GET        = 3'd2;
  localparam logic [2:0] OP_ALIGN      = 3'd3;
  localparam logic [2:0] OP_SKIP_BYTES = 3'd4;
  localparam logic [2:0] OP_SKIP_BITS  = 3'd5;

  // Fixed field widths.
  localparam int FIELD_W = 64;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 16;
  localparam int OFFS_W  = 3;
  localparam int POS_W   = INDEX_W + OFFS_W;
  localparam int LEN_W   = 13;
  // Wide enough for a byte address past the top of the largest store.
  localparam int BADDR_W = 17;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] load_address;
    logic [7:0]  load_value;
    logic [6:0]  field_bits;
    logic [15:0] skip_amount;
  } lbr_item_t;

  typedef struct packed {
    logic [63:0] field_value;
    logic [15:0] byte_position;
    logic [2:0]  bit_position;
    logic        past_end;
  } lbr_result_t;

  // Control carried alongside the store read into the extraction stage.
  typedef struct packed {
    logic               is_read;
    logic [INDEX_W-1:0] byte_index;
    logic [OFFS_W-1:0]  bit_offset;
    logic [COUNT_W-1:0] field_bits;
    logic [INDEX_W-1:0] next_index;
    logic [OFFS_W-1:0]  next_offset;
  } lbr_ctrl_t;

endpackage

/* rtl/lbr_intf.sv */
`timescale 1ns / 1ps
// Handshake channels of the bit reader: input words, result words and
// the block-length write channel. Depends on lbr_pkg.
interface lbr_item_if import lbr_pkg::*; ();
  logic      valid;
  logic      ready;
  lbr_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lbr_result_if import lbr_pkg::*; ();
  logic        valid;
  logic        ready;
  lbr_result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lbr_cfg_if import lbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/lbr_store.sv */
`timescale 1ns / 1ps
// Banked byte store: one byte written per cycle, a window of consecutive
// bytes read per cycle with registered read data. Depends on lbr_pkg.
module lbr_store import lbr_pkg::*; #(
  parameter int STORE_BYTES = 4096,
  parameter int NUM_BANKS   = 16
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(STORE_BYTES)-1:0]    wr_addr,
  input  logic [7:0]                        wr_data,
  input  logic                              rd_en,
  input  logic [INDEX_W-1:0]                rd_index,
  output logic [NUM_BANKS-1:0][7:0]         rd_data
);

  localparam int BANK_W     = $clog2(NUM_BANKS);
  localparam int BANK_DEPTH = (STORE_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [BADDR_W-1:0] wr_wide;
  logic [ROW_W-1:0]   wr_row;
  logic [BANK_W-1:0]  wr_bank;

  // Byte address a splits into bank a mod NUM_BANKS and row a / NUM_BANKS.
  assign wr_wide = BADDR_W'(wr_addr);
  assign wr_row  = wr_wide[BANK_W +: ROW_W];
  assign wr_bank = wr_wide[BANK_W-1:0];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [7:0]         mem [BANK_DEPTH];
    logic [BANK_W-1:0]  lead;
    logic [BADDR_W-1:0] rd_wide;
    logic [ROW_W-1:0]   rd_row;

    // Bank b holds the window byte that lies lead bytes after rd_index.
    assign lead    = BANK_W'(b) - rd_index[BANK_W-1:0];
    assign rd_wide = BADDR_W'(rd_index) + BADDR_W'(lead);
    assign rd_row  = rd_wide[BANK_W +: ROW_W];

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == BANK_W'(b)) begin
        mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
        rd_data[b] <= mem[rd_row];
      end
    end
  end

endmodule

/* rtl/lbr_extract.sv */
`timescale 1ns / 1ps
// Field extraction: orders the bank outputs into a byte window, zeroes
// bytes past the valid length, shifts, masks and flags past_end. Uses lbr_pkg.
module lbr_extract import lbr_pkg::*; #(
  parameter int FETCH_BYTES = 9,
  parameter int NUM_BANKS   = 16
) (
  input  logic [NUM_BANKS-1:0][7:0] rd_data,
  input  lbr_ctrl_t                 ctrl,
  input  logic [BADDR_W-1:0]        valid_len,
  output logic [FIELD_W-1:0]        field_value,
  output logic                      past_end
);

  localparam int BANK_W = $clog2(NUM_BANKS);
  localparam int WIN_W  = FETCH_BYTES * 8;

  logic [WIN_W-1:0]   window;
  logic [WIN_W-1:0]   shifted;
  logic [BADDR_W-1:0] baddr;
  logic [BANK_W-1:0]  bsel;
  logic [FIELD_W-1:0] mask;
  logic [7:0]         span;
  logic [BADDR_W-1:0] last_byte;

  // Gather the window in order; bytes at or beyond the valid length read as zero.
  always_comb begin
    window = '0;
    baddr  = '0;
    bsel   = '0;
    for (int k = 0; k < FETCH_BYTES; k++) begin
      baddr = BADDR_W'(ctrl.byte_index) + BADDR_W'(k);
      bsel  = ctrl.byte_index[BANK_W-1:0] + BANK_W'(k);
      window[8*k +: 8] = (baddr < valid_len) ? rd_data[bsel] : 8'h00;
    end
  end

  // Drop the bits below the read offset and keep only the requested count.
  assign shifted = window >> ctrl.bit_offset;
  assign mask    = (ctrl.field_bits >= COUNT_W'(FIELD_W)) ? '1 :
                   ((FIELD_W'(1) << ctrl.field_bits) - FIELD_W'(1));
  assign field_value = ctrl.is_read ? (FIELD_W'(shifted) & mask) : '0;

  // The last byte touched is index + (offset + count - 1) / 8.
  assign span      = 8'(ctrl.bit_offset) + 8'(ctrl.field_bits) - 8'd1;
  assign last_byte = BADDR_W'(ctrl.byte_index) + BADDR_W'(span[7:3]);
  assign past_end  = ctrl.is_read && (ctrl.field_bits != '0) && (last_byte >= valid_len);

endmodule

/* rtl/lsb_first_bit_reader.sv */
`timescale 1ns / 1ps
// Top level of the LSB-first bit reader: read position, banked store and
// result register. Depends on lbr_pkg, lbr_intf, lbr_store and lbr_extract.

// The reader takes one word per clock cycle and returns one result word for
// each, in order; a result is offered on the result channel once its word has
// passed the store read stage (the banked byte store is read on the accepting
// edge) and field extraction has loaded the result register, and a stalled
// result channel holds back new words only once both of those stages are
// full. The store is split into sixteen byte-wide banks so that the nine
// bytes a 64-bit field can straddle are read in a single cycle; the read
// position is updated as each word is taken, so a get may be followed
// directly by another read. The store has no reset and needs no clearing:
// bytes below block_length must be written before they are read. The user
// must write block_length through the cfg channel only while no word is in
// flight; the block itself does not enforce this.
module lsb_first_bit_reader import lbr_pkg::*; #(
  parameter int STORE_BYTES    = 4096,
  parameter int MAX_FIELD_BITS = 64
) (
  input logic          clk,
  input logic          rst,
  lbr_item_if.sink     items,
  lbr_result_if.source results,
  lbr_cfg_if.sink      cfg
);

  localparam int FETCH_BYTES = (MAX_FIELD_BITS + 14) / 8;
  localparam int NUM_BANKS   = 2 ** $clog2(FETCH_BYTES);
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  logic [LEN_W-1:0]   block_length;
  logic [BADDR_W-1:0] valid_len;
  logic [INDEX_W-1:0] read_index;
  logic [OFFS_W-1:0]  read_offset;
  logic [POS_W-1:0]   pos_cur;
  logic [POS_W:0]     pos_sum;
  logic [POS_W-1:0]   pos_next;
  logic [COUNT_W-1:0] count;
  logic               accept;
  logic               s1_valid;
  logic               s1_adv;
  lbr_ctrl_t          s1_ctrl;
  logic [NUM_BANKS-1:0][7:0] rd_data;
  logic [BADDR_W-1:0] wr_wide;
  logic               wr_en;
  logic               rd_en;
  logic [FIELD_W-1:0] ext_field;
  logic               ext_past;

  // Configuration register.
  assign cfg.ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= '0;
    end else if (cfg.valid && cfg.ready) begin
      block_length <= cfg.data;
    end
  end

  assign valid_len = (BADDR_W'(block_length) < BADDR_W'(STORE_BYTES)) ?
                     BADDR_W'(block_length) : BADDR_W'(STORE_BYTES);

  // Flow control: a word enters when the extraction stage is empty or moving.
  assign s1_adv       = !results.valid || results.ready;
  assign items.ready  = !rst && (!s1_valid || s1_adv);
  assign accept       = items.valid && items.ready;

  // Clamp the requested count to the widest field.
  assign count = (items.payload.field_bits > COUNT_W'(MAX_FIELD_BITS)) ?
                 COUNT_W'(MAX_FIELD_BITS) : items.payload.field_bits;

  // Position after this word, saturating at the top of the bit range.
  assign pos_cur = {read_index, read_offset};
  always_comb begin
    unique case (items.payload.operation)
      OP_GET:        pos_sum = {1'b0, pos_cur} + (POS_W + 1)'(count);
      OP_ALIGN:      pos_sum = ({1'b0, pos_cur} + (POS_W + 1)'(7)) &
                               ~(POS_W + 1)'(7);
      OP_SKIP_BYTES: pos_sum = {1'b0, pos_cur} +
                               (POS_W + 1)'({items.payload.skip_amount, 3'b000});
      OP_SKIP_BITS:  pos_sum = {1'b0, pos_cur} +
                               (POS_W + 1)'(items.payload.skip_amount);
      default:       pos_sum = {1'b0, pos_cur};
    endcase
  end
  assign pos_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];

  // Store access for the accepted word.
  assign wr_wide = BADDR_W'(items.payload.load_address);
  assign wr_en   = accept && (items.payload.operation == OP_WRITE) &&
                   (wr_wide < BADDR_W'(STORE_BYTES));
  assign rd_en   = accept && ((items.payload.operation == OP_PEEK) ||
                              (items.payload.operation == OP_GET));

  lbr_store #(
    .STORE_BYTES (STORE_BYTES),
    .NUM_BANKS   (NUM_BANKS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_wide[ADDR_W-1:0]),
    .wr_data  (items.payload.load_value),
    .rd_en    (rd_en),
    .rd_index (read_index),
    .rd_data  (rd_data)
  );

  // Read position and the control word that travels with the store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      read_offset <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        read_index  <= pos_next[POS_W-1:OFFS_W];
        read_offset <= pos_next[OFFS_W-1:0];
        s1_valid    <= 1'b1;
      end else if (s1_adv) begin
        s1_valid    <= 1'b0;
      end
    end
    if (accept) begin
      s1_ctrl.is_read     <= rd_en;
      s1_ctrl.byte_index  <= read_index;
      s1_ctrl.bit_offset  <= read_offset;
      s1_ctrl.field_bits  <= count;
      s1_ctrl.next_index  <= pos_next[POS_W-1:OFFS_W];
      s1_ctrl.next_offset <= pos_next[OFFS_W-1:0];
    end
  end

  lbr_extract #(
    .FETCH_BYTES (FETCH_BYTES),
    .NUM_BANKS   (NUM_BANKS)
  ) u_extract (
    .rd_data     (rd_data),
    .ctrl        (s1_ctrl),
    .valid_len   (valid_len),
    .field_value (ext_field),
    .past_end    (ext_past)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s1_adv) begin
      results.valid <= s1_valid;
    end
    if (s1_adv && s1_valid) begin
      results.payload.field_value   <= ext_field;
      results.payload.byte_position <= s1_ctrl.next_index;
      results.payload.bit_position  <= s1_ctrl.next_offset;
      results.payload.past_end      <= ext_past;
    end
  end

endmodule
